// ===== rtl/core/chisq_pkg.sv =====
// Package: shared constants, request codes and controller state type for the chi-square table.
`timescale 1ns / 1ps
package chisq_pkg;

  localparam int unsigned MAX_ROWS_DEF = 64;
  localparam int unsigned MAX_COLS_DEF = 16;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ALPHA_W = 24;
  localparam int unsigned DF_W    = 16;
  localparam int unsigned ROWS_W  = 7;
  localparam int unsigned COLS_W  = 5;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd35;
  localparam logic [COLS_W-1:0] COLS_RESET = 5'd12;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;

  // request codes
  localparam logic [2:0] REQ_LD_LABEL = 3'd0;
  localparam logic [2:0] REQ_LD_ALPHA = 3'd1;
  localparam logic [2:0] REQ_LD_CHI   = 3'd2;
  localparam logic [2:0] REQ_CHI      = 3'd3;
  localparam logic [2:0] REQ_P        = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_CMP,
    ST_M_RD,
    ST_M_CMP,
    ST_R_RD,
    ST_R_CMP,
    ST_X2_RD,
    ST_X2_CMP,
    ST_X1_RD,
    ST_Y1_RD,
    ST_Y2_RD,
    ST_Y2_CAP,
    ST_C_RD,
    ST_C_CMP,
    ST_B_RD,
    ST_B_CMP,
    ST_P1_RD,
    ST_P2_RD,
    ST_P_CAP,
    ST_FIN_RD,
    ST_FIN_OUT,
    ST_MD_WAIT
  } ctl_state_e;

endpackage

// ===== rtl/core/chisq_muldiv.sv =====
// Multiply-then-divide unit: registered 32x32 product followed by a restoring divide.
`timescale 1ns / 1ps
module chisq_muldiv
  import chisq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [DATA_W-1:0] mcand_i,
  input  logic [DATA_W-1:0] mplier_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  // one quotient bit per cycle; the partial remainder stays below the divisor
  always_comb begin
    prod  = mcand_i * mplier_i;
    trial = {rem_q, quo_q[DATA_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (go_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = prod[2*DATA_W-1:DATA_W];
      quo_d = prod[DATA_W-1:0];
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

`ifndef NO_ASSERTIONS
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !$past(go_i) |-> rem_q < dvs_q)
    else $error("divide remainder not below divisor");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held longer than one cycle");
  a_go_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |=> run_q)
    else $error("divide did not start");
`endif

endmodule

// ===== rtl/core/chi_square_table_interpolator_top.sv =====
// Top level: chi-square table stores, search sequencer and lookup result register.
`timescale 1ns / 1ps
// Each binary search step is a memory read followed by a compare.
// A chi lookup searches the alpha levels, checks for an exact alpha match, then
// searches the row labels; a p lookup searches the row labels, then the chi
// values of that row. When the key falls between two table entries, the
// multiply and the 32-step divide interpolate the result. Loads produce no
// result. Each result appears for one cycle on done_o and cannot be stalled;
// busy_o drops in that same cycle so the next request may start.
// The configuration channel always accepts and must only be written while idle.
module chi_square_table_interpolator_top
  import chisq_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         req_type_i,
  input  logic [5:0]         row_index_i,
  input  logic [3:0]         col_index_i,
  input  logic [DF_W-1:0]    df_value_i,
  input  logic [ALPHA_W-1:0] alpha_value_i,
  input  logic [DATA_W-1:0]  chi_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [ROWS_W-1:0]  cfg_data_i,
  output logic               done_o,
  output logic               status_o,
  output logic [DATA_W-1:0]  chi_result_o,
  output logic [ALPHA_W-1:0] p_result_o
);

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned SW  = ((RW > CW) ? RW : CW) + 1;
  localparam int unsigned CD  = MAX_ROWS * MAX_COLS;
  localparam int unsigned CAW = $clog2(CD);

  ctl_state_e state_q, state_d;

  logic [ROWS_W-1:0]  rows_q;
  logic [COLS_W-1:0]  cols_q;
  logic [SW-1:0]      nr, nc;

  logic               is_p_q, is_p_d;
  logic [DF_W-1:0]    df_q, df_d;
  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic [DATA_W-1:0]  chi_q, chi_d;
  logic [SW-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [RW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic [DATA_W-1:0]  x1_q, x1_d, x2_q, x2_d, base_q, base_d;
  logic               sub_q, sub_d;

  logic               done_q, done_d;
  logic               status_q, status_d;
  logic [DATA_W-1:0]  chi_res_q, chi_res_d;
  logic [ALPHA_W-1:0] p_res_q, p_res_d;

  logic [DF_W-1:0]    label_mem [MAX_ROWS];
  logic [ALPHA_W-1:0] alpha_mem [MAX_COLS];
  logic [DATA_W-1:0]  chi_mem   [CD];
  logic [DF_W-1:0]    label_rd_q;
  logic [ALPHA_W-1:0] alpha_rd_q;
  logic [DATA_W-1:0]  chi_rd_q;
  logic [RW-1:0]      label_ra;
  logic [CW-1:0]      alpha_ra;
  logic [RW-1:0]      chi_rrow;
  logic [CW-1:0]      chi_rcol;
  logic [CAW-1:0]     chi_ra, chi_wa;

  logic               accept;
  logic               row_ok, col_ok;
  logic [SW:0]        mid_sum;
  logic [SW-1:0]      mid, nlo, nhi;
  logic               go_right, searching;
  logic               emit, emit_bad;
  logic [DATA_W-1:0]  emit_val;
  logic [DATA_W-1:0]  abs_dy;

  logic               md_go, md_done;
  logic [DATA_W-1:0]  md_a, md_b, md_div, md_quot;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign row_ok      = (32'(row_index_i) < MAX_ROWS);
  assign col_ok      = (32'(col_index_i) < MAX_COLS);
  assign chi_wa      = CAW'(RW'(row_index_i)) * CAW'(MAX_COLS) + CAW'(CW'(col_index_i));
  assign chi_ra      = CAW'(chi_rrow) * CAW'(MAX_COLS) + CAW'(chi_rcol);

  // clamp the configured table size to the stores
  always_comb begin
    if (rows_q == '0) nr = SW'(1);
    else if (32'(rows_q) > MAX_ROWS) nr = SW'(MAX_ROWS);
    else nr = SW'(rows_q);
    if (cols_q == '0) nc = SW'(1);
    else if (32'(cols_q) > MAX_COLS) nc = SW'(MAX_COLS);
    else nc = SW'(cols_q);
  end

  // binary search step shared by the three searches
  always_comb begin
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid     = mid_sum[SW:1];
    case (state_q)
      ST_A_CMP: go_right = (alpha_q < alpha_rd_q);
      ST_R_CMP: go_right = (df_q > label_rd_q);
      default:  go_right = (chi_q > chi_rd_q);
    endcase
    nlo       = go_right ? mid + 1'b1 : lo_q;
    nhi       = go_right ? hi_q : mid;
    searching = (nlo < nhi);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_type_i == REQ_CHI) state_d = ST_A_RD;
        else if (accept && req_type_i == REQ_P) state_d = ST_R_RD;
      end
      ST_A_RD:   state_d = ST_A_CMP;
      ST_A_CMP:  state_d = searching ? ST_A_RD : ST_M_RD;
      ST_M_RD:   state_d = (lo_q >= nc) ? ST_IDLE : ST_M_CMP;
      ST_M_CMP:  state_d = (alpha_rd_q != alpha_q) ? ST_IDLE : ST_R_RD;
      ST_R_RD:   state_d = ST_R_CMP;
      ST_R_CMP: begin
        if (searching) state_d = ST_R_RD;
        else if (is_p_q) state_d = ST_C_RD;
        else if (nlo >= nr) state_d = ST_FIN_RD;
        else state_d = ST_X2_RD;
      end
      ST_X2_RD:  state_d = ST_X2_CMP;
      ST_X2_CMP: state_d = (df_q < label_rd_q && row_q != '0) ? ST_X1_RD : ST_FIN_RD;
      ST_X1_RD:  state_d = ST_Y1_RD;
      ST_Y1_RD:  state_d = ST_Y2_RD;
      ST_Y2_RD:  state_d = ST_Y2_CAP;
      ST_Y2_CAP: state_d = ST_MD_WAIT;
      ST_C_RD:   state_d = ST_C_CMP;
      ST_C_CMP:  state_d = searching ? ST_C_RD : ST_B_RD;
      ST_B_RD:   state_d = ST_B_CMP;
      ST_B_CMP:  state_d = (chi_q < chi_rd_q && col_q != '0) ? ST_P1_RD : ST_FIN_RD;
      ST_P1_RD:  state_d = ST_P2_RD;
      ST_P2_RD:  state_d = ST_P_CAP;
      ST_P_CAP:  state_d = ST_MD_WAIT;
      ST_FIN_RD: state_d = ST_FIN_OUT;
      ST_FIN_OUT: state_d = ST_IDLE;
      ST_MD_WAIT: state_d = md_done ? ST_IDLE : ST_MD_WAIT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control, memory addresses and result capture
  always_comb begin
    is_p_d   = is_p_q;
    df_d     = df_q;
    alpha_d  = alpha_q;
    chi_d    = chi_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    row_d    = row_q;
    col_d    = col_q;
    x1_d     = x1_q;
    x2_d     = x2_q;
    base_d   = base_q;
    sub_d    = sub_q;
    label_ra = '0;
    alpha_ra = '0;
    chi_rrow = row_q;
    chi_rcol = col_q;
    emit     = 1'b0;
    emit_bad = 1'b0;
    emit_val = '0;
    md_go    = 1'b0;
    md_a     = '0;
    md_b     = '0;
    md_div   = x2_q - x1_q;
    abs_dy   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          is_p_d  = (req_type_i == REQ_P);
          df_d    = df_value_i;
          alpha_d = alpha_value_i;
          chi_d   = chi_value_i;
          lo_d    = '0;
          hi_d    = (req_type_i == REQ_P) ? nr : nc;
        end
      end
      ST_A_RD: alpha_ra = mid[CW-1:0];
      ST_A_CMP, ST_C_CMP: begin
        lo_d = nlo;
        hi_d = nhi;
        if (state_q == ST_C_CMP && !searching) begin
          col_d = (nlo >= nc) ? CW'(nc - 1'b1) : CW'(nlo);
        end
      end
      ST_M_RD: begin
        alpha_ra = lo_q[CW-1:0];
        col_d    = lo_q[CW-1:0];
        if (lo_q >= nc) begin
          emit     = 1'b1;
          emit_bad = 1'b1;
        end
      end
      ST_M_CMP: begin
        lo_d = '0;
        hi_d = nr;
        if (alpha_rd_q != alpha_q) begin
          emit     = 1'b1;
          emit_bad = 1'b1;
        end
      end
      ST_R_RD: label_ra = mid[RW-1:0];
      ST_R_CMP: begin
        lo_d = nlo;
        hi_d = nhi;
        if (!searching) begin
          row_d = (nlo >= nr) ? RW'(nr - 1'b1) : RW'(nlo);
          if (is_p_q) begin
            lo_d = '0;
            hi_d = nc;
          end
        end
      end
      ST_X2_RD:  label_ra = row_q;
      ST_X2_CMP: x2_d = DATA_W'(label_rd_q);
      ST_X1_RD:  label_ra = row_q - 1'b1;
      ST_Y1_RD: begin
        x1_d     = DATA_W'(label_rd_q);
        chi_rrow = row_q - 1'b1;
      end
      ST_Y2_RD:  base_d = chi_rd_q;
      ST_Y2_CAP: begin
        // chi = y1 + (df - x1) * (y2 - y1) / (x2 - x1)
        abs_dy = (chi_rd_q >= base_q) ? chi_rd_q - base_q : base_q - chi_rd_q;
        sub_d  = (chi_rd_q < base_q);
        md_go  = 1'b1;
        md_a   = DATA_W'(df_q) - x1_q;
        md_b   = abs_dy;
      end
      ST_C_RD:  chi_rcol = mid[CW-1:0];
      ST_B_CMP: x2_d = chi_rd_q;
      ST_P1_RD: begin
        chi_rcol = col_q - 1'b1;
        alpha_ra = col_q - 1'b1;
      end
      ST_P2_RD: begin
        x1_d     = chi_rd_q;
        base_d   = DATA_W'(alpha_rd_q);
        alpha_ra = col_q;
      end
      ST_P_CAP: begin
        // p = a1 - (chi - x1) * (a1 - a2) / (x2 - x1)
        abs_dy = (base_q >= DATA_W'(alpha_rd_q)) ? base_q - DATA_W'(alpha_rd_q)
                                                 : DATA_W'(alpha_rd_q) - base_q;
        sub_d  = (base_q >= DATA_W'(alpha_rd_q));
        md_go  = 1'b1;
        md_a   = chi_q - x1_q;
        md_b   = abs_dy;
      end
      ST_FIN_RD: alpha_ra = col_q;
      ST_FIN_OUT: begin
        emit     = 1'b1;
        emit_val = is_p_q ? DATA_W'(alpha_rd_q) : chi_rd_q;
      end
      ST_MD_WAIT: begin
        if (md_done) begin
          emit     = 1'b1;
          emit_val = sub_q ? base_q - md_quot : base_q + md_quot;
        end
      end
      default: ;
    endcase
    done_d    = emit;
    status_d  = emit_bad;
    chi_res_d = (!is_p_q && !emit_bad) ? emit_val : '0;
    p_res_d   = is_p_q ? emit_val[ALPHA_W-1:0] : '0;
  end

  // control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      rows_q  <= ROWS_RESET;
      cols_q  <= COLS_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ROWS: rows_q <= cfg_data_i;
          CFG_COLS: cols_q <= cfg_data_i[COLS_W-1:0];
          default:  ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    is_p_q    <= is_p_d;
    df_q      <= df_d;
    alpha_q   <= alpha_d;
    chi_q     <= chi_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    row_q     <= row_d;
    col_q     <= col_d;
    x1_q      <= x1_d;
    x2_q      <= x2_d;
    base_q    <= base_d;
    sub_q     <= sub_d;
    status_q  <= status_d;
    chi_res_q <= chi_res_d;
    p_res_q   <= p_res_d;
  end

  // row label store
  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_LD_LABEL && row_ok) begin
      label_mem[RW'(row_index_i)] <= df_value_i;
    end
    label_rd_q <= label_mem[label_ra];
  end

  // alpha level store
  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_LD_ALPHA && col_ok) begin
      alpha_mem[CW'(col_index_i)] <= alpha_value_i;
    end
    alpha_rd_q <= alpha_mem[alpha_ra];
  end

  // critical value store, row-major
  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_LD_CHI && row_ok && col_ok) begin
      chi_mem[chi_wa] <= chi_value_i;
    end
    chi_rd_q <= chi_mem[chi_ra];
  end

  chisq_muldiv u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (md_go),
    .mcand_i   (md_a),
    .mplier_i  (md_b),
    .divisor_i (md_div),
    .done_o    (md_done),
    .quot_o    (md_quot)
  );

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign chi_result_o = chi_res_q;
  assign p_result_o   = p_res_q;

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result issued while a transaction is still in flight");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q |-> chi_res_q == '0 && p_res_q == '0)
    else $error("unmatched alpha result carries a value");
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == REQ_CHI || req_type_i == REQ_P) |=> busy_o)
    else $error("lookup transaction did not start");
`endif

endmodule
